// ===== src/lbci_pkg.sv =====
// Shared types and constants for the bilinear channel interpolator.
package lbci_pkg;

  localparam int GRID_SIDE_DEF     = 32;
  localparam int CHANNELS_DEF      = 32;
  localparam int FRACTION_BITS_DEF = 8;

  // at most this many channels are emitted per query
  localparam int MAX_OUT = 32;

  localparam int COORD_W = 16;
  localparam int CELL_W  = 10;
  localparam int CHAN_W  = 5;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 6;

  localparam logic [CFG_W-1:0] SIDE_RESET     = 6'd32;
  localparam logic [CFG_W-1:0] CHANNELS_RESET = 6'd32;

  // register indexes, decoded from paddr[2]
  localparam logic [0:0] REG_SIDE     = 1'b0;
  localparam logic [0:0] REG_CHANNELS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_CELL,
    ST_BASE,
    ST_RUN
  } lbci_state_t;

  // tag that travels beside each issued set of four reads
  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] channel;
    logic              last;
  } issue_tag_t;

endpackage

// ===== src/lbci_ram.sv =====
// Table memory copy: one write port, two registered read ports.
module lbci_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== src/lbci_seq.sv =====
// Query sequencer: clamps coordinates, forms neighbour cells and weights, walks channels.
module lbci_seq import lbci_pkg::*; #(
  parameter int GRID_SIDE     = GRID_SIDE_DEF,
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int SIDE_W  = $clog2(GRID_SIDE + 1),
  localparam int XW      = $clog2(GRID_SIDE),
  localparam int CELLS   = GRID_SIDE * GRID_SIDE,
  localparam int CELL_AW = $clog2(CELLS),
  localparam int DEPTH   = CELLS * CHANNELS,
  localparam int AW      = $clog2(DEPTH),
  localparam int WW      = 2 * FRACTION_BITS + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic [CFG_W-1:0]          side_cfg,
  input  logic [CFG_W-1:0]          chan_cfg,
  input  logic                      advance,
  output logic                      busy,
  output issue_tag_t                tag,
  output logic [AW-1:0]             raddr [4],
  output logic [WW-1:0]             weight [4]
);

  localparam int NCH_MAX = (CHANNELS < MAX_OUT) ? CHANNELS : MAX_OUT;
  localparam int ONE     = 1 << FRACTION_BITS;

  lbci_state_t state, state_next;

  logic signed [COORD_W-1:0] cx_raw, cy_raw;
  logic [SIDE_W-1:0]         side_eff, side_c;
  logic [XW-1:0]             x0, x1, y0, y1;
  logic [XW-1:0]             x0_c, x1_c, y0_c, y1_c;
  logic [FRACTION_BITS-1:0]  fx, fy;
  logic [COORD_W-1:0]        cx_c, cy_c;
  logic [31:0]               hi_c;
  logic [CELL_AW-1:0]        nbr_cell [4];
  logic [AW-1:0]             base [4];
  logic [WW-1:0]             wt [4];
  logic [FRACTION_BITS:0]    omfx, omfy;
  logic [CHAN_W-1:0]         k;
  logic [CFG_W-1:0]          nch, nch_c;
  logic                      last_c;
  logic                      issue;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] c,
                                                      input logic [31:0] hi);
    logic [COORD_W-1:0] r;
    if (c[COORD_W-1]) begin
      r = '0;
    end else if (32'(c) > hi) begin
      r = COORD_W'(hi);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // effective side and channel count from the registers
  always_comb begin
    if (32'(side_cfg) < 32'd2) begin
      side_c = SIDE_W'(2);
    end else if (32'(side_cfg) > 32'(GRID_SIDE)) begin
      side_c = SIDE_W'(GRID_SIDE);
    end else begin
      side_c = SIDE_W'(side_cfg);
    end
    if (chan_cfg == '0) begin
      nch_c = CFG_W'(1);
    end else if (32'(chan_cfg) > 32'(NCH_MAX)) begin
      nch_c = CFG_W'(NCH_MAX);
    end else begin
      nch_c = chan_cfg;
    end
  end

  always_comb begin
    hi_c = 32'(side_c - SIDE_W'(1)) << FRACTION_BITS;
    cx_c = clamp_coord(cx_raw, hi_c);
    cy_c = clamp_coord(cy_raw, hi_c);
    x0_c = XW'(32'(cx_c) >> FRACTION_BITS);
    y0_c = XW'(32'(cy_c) >> FRACTION_BITS);
    x1_c = (32'(x0_c) + 32'd1 < 32'(side_c)) ? XW'(x0_c + XW'(1)) : XW'(side_c - SIDE_W'(1));
    y1_c = (32'(y0_c) + 32'd1 < 32'(side_c)) ? XW'(y0_c + XW'(1)) : XW'(side_c - SIDE_W'(1));
    omfx = (FRACTION_BITS + 1)'(ONE - 32'(fx));
    omfy = (FRACTION_BITS + 1)'(ONE - 32'(fy));
  end

  assign last_c = (CFG_W'(k) + CFG_W'(1)) == nch;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_CELL;
      ST_CELL:  state_next = ST_BASE;
      ST_BASE:  state_next = ST_RUN;
      ST_RUN:   if (advance && last_c) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    case (state)
      ST_IDLE: busy  = 1'b0;
      ST_RUN:  issue = advance;
      default: busy  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          cx_raw <= coord_x;
          cy_raw <= coord_y;
        end
      end
      ST_CLAMP: begin
        side_eff <= side_c;
        x0 <= x0_c;
        x1 <= x1_c;
        y0 <= y0_c;
        y1 <= y1_c;
        fx <= cx_c[FRACTION_BITS-1:0];
        fy <= cy_c[FRACTION_BITS-1:0];
      end
      ST_CELL: begin
        nbr_cell[0] <= CELL_AW'(32'(x0) * 32'(side_eff) + 32'(y0));
        nbr_cell[1] <= CELL_AW'(32'(x1) * 32'(side_eff) + 32'(y0));
        nbr_cell[2] <= CELL_AW'(32'(x0) * 32'(side_eff) + 32'(y1));
        nbr_cell[3] <= CELL_AW'(32'(x1) * 32'(side_eff) + 32'(y1));
        wt[0] <= WW'(omfx) * WW'(omfy);
        wt[1] <= WW'(fx) * WW'(omfy);
        wt[2] <= WW'(omfx) * WW'(fy);
        wt[3] <= WW'(fx) * WW'(fy);
      end
      ST_BASE: begin
        for (int i = 0; i < 4; i++) begin
          base[i] <= AW'(32'(nbr_cell[i]) * CHANNELS);
        end
        k   <= '0;
        nch <= nch_c;
      end
      ST_RUN: begin
        if (advance) begin
          k <= k + CHAN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      raddr[i]  = base[i] + AW'(k);
      weight[i] = wt[i];
    end
    tag.valid   = issue;
    tag.channel = k;
    tag.last    = last_c;
  end

endmodule

// ===== src/lbci_blend.sv =====
// Blend pipeline: weight products, sum with rounding, saturation, output register.
module lbci_blend import lbci_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int WW = 2 * FRACTION_BITS + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  issue_tag_t         tag,
  input  logic [VALUE_W-1:0] entry [4],
  input  logic [WW-1:0]      weight [4],
  input  logic               out_ready,
  output logic               advance,
  output logic               head_valid,
  output logic               out_valid,
  output logic [CHAN_W-1:0]  out_channel,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_last
);

  localparam int PW = VALUE_W + WW + 1;
  localparam int SW = PW + 2;
  localparam int VW = SW - 2 * FRACTION_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (2 * FRACTION_BITS - 1);
  localparam logic signed [VW-1:0] VMAX = {{(VW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {{(VW - 31){1'b1}}, {31{1'b0}}};

  issue_tag_t tag_a, tag_b, tag_c;
  logic signed [PW-1:0] prod [4];
  logic signed [SW-1:0] sum;
  logic signed [VW-1:0] shifted;
  logic [VALUE_W-1:0]   sat;

  // whole pipeline moves together; it holds while the output waits
  assign advance    = !out_valid || out_ready;
  assign head_valid = tag_a.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a.valid <= 1'b0;
      tag_b.valid <= 1'b0;
      tag_c.valid <= 1'b0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      tag_a.valid <= tag.valid;
      tag_b.valid <= tag_a.valid;
      tag_c.valid <= tag_b.valid;
      out_valid   <= tag_c.valid;
    end
    if (advance) begin
      tag_a.channel <= tag.channel;
      tag_a.last    <= tag.last;
      tag_b.channel <= tag_a.channel;
      tag_b.last    <= tag_a.last;
      tag_c.channel <= tag_b.channel;
      tag_c.last    <= tag_b.last;
      for (int i = 0; i < 4; i++) begin
        prod[i] <= $signed(entry[i]) * $signed({1'b0, weight[i]});
      end
      sum <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(prod[3]) + HALF;
      out_channel <= tag_c.channel;
      out_last    <= tag_c.last;
      out_value   <= sat;
    end
  end

  // floor shift after the half was added gives round half up
  always_comb begin
    shifted = sum[SW-1:2*FRACTION_BITS];
    if (shifted > VMAX) begin
      sat = VALUE_W'(VMAX);
    end else if (shifted < VMIN) begin
      sat = VALUE_W'(VMIN);
    end else begin
      sat = VALUE_W'(shifted);
    end
  end

endmodule

// ===== src/lut_bilinear_channel_interpolator.sv =====
// Top level of the bilinear channel interpolator over a square grid table.
// A load transaction (tuser = 0) writes one table entry and leaves the input ready again
// at once. A query transaction (tuser = 1) passes through the clamp, cell and base setup
// states after acceptance and then issues one channel per cycle while the output does not
// stall (channels_in_use, clamped to 1..min(CHANNELS, 32)); the input reopens when the
// last channel's reads have left the head of the blend pipeline. The rate is set by the
// four table reads each channel needs, served by two identical table copies with two read
// ports each. Results pass through the read, product, sum and output registers, the last
// channel marked by tlast. A stalled output holds the whole blend pipeline. The table is
// not cleared by reset; entries must be loaded before a query reads them.
module lut_bilinear_channel_interpolator import lbci_pkg::*; #(
  parameter int GRID_SIDE     = GRID_SIDE_DEF,
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cell_index[9:0], channel_index[14:10], entry_value[46:15], coord_x[62:47],
  // coord_y[78:63], zero pad[79]
  input  logic [79:0] s_tdata,
  // operation[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // channel[4:0], value[36:5], zero pad[39:37]
  output logic [39:0] m_tdata,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int DEPTH = CELLS * CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = 2 * FRACTION_BITS + 1;

  logic [CFG_W-1:0] side_in_use, channels_in_use;
  logic             cfg_write;

  logic [CELL_W-1:0]         cell_index;
  logic [CHAN_W-1:0]         channel_index;
  logic [VALUE_W-1:0]        entry_value;
  logic signed [COORD_W-1:0] coord_x, coord_y;
  logic                      accept, start, load_we;
  logic [AW-1:0]             waddr;

  logic               busy, advance, head_valid;
  issue_tag_t         tag;
  logic [AW-1:0]      raddr [4];
  logic [WW-1:0]      weight [4];
  logic [VALUE_W-1:0] entry [4];
  logic [CHAN_W-1:0]  out_channel;
  logic [VALUE_W-1:0] out_value;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_in_use     <= SIDE_RESET;
      channels_in_use <= CHANNELS_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SIDE:     side_in_use     <= pwdata[CFG_W-1:0];
        REG_CHANNELS: channels_in_use <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SIDE:     prdata = 32'(side_in_use);
      REG_CHANNELS: prdata = 32'(channels_in_use);
      default:      prdata = '0;
    endcase
  end

  // input transaction decode
  assign cell_index    = s_tdata[9:0];
  assign channel_index = s_tdata[14:10];
  assign entry_value   = s_tdata[46:15];
  assign coord_x       = s_tdata[62:47];
  assign coord_y       = s_tdata[78:63];

  // a new transaction waits until the last query's reads have taken their weights
  assign s_tready = !busy && !head_valid;
  assign accept   = s_tvalid && s_tready;
  assign start    = accept && s_tuser[0];
  assign load_we  = accept && !s_tuser[0] &&
                    (32'(cell_index) < 32'(CELLS)) && (32'(channel_index) < 32'(CHANNELS));
  assign waddr    = AW'(32'(cell_index) * CHANNELS + 32'(channel_index));

  lbci_seq #(
    .GRID_SIDE    (GRID_SIDE),
    .CHANNELS     (CHANNELS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .side_cfg(side_in_use),
    .chan_cfg(channels_in_use),
    .advance (advance),
    .busy    (busy),
    .tag     (tag),
    .raddr   (raddr),
    .weight  (weight)
  );

  // two copies of the table give four reads per cycle while the pipeline advances
  lbci_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (VALUE_W)
  ) u_ram_lo (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (entry_value),
    .re    (advance),
    .raddr0(raddr[0]),
    .raddr1(raddr[1]),
    .rdata0(entry[0]),
    .rdata1(entry[1])
  );

  lbci_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (VALUE_W)
  ) u_ram_hi (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (entry_value),
    .re    (advance),
    .raddr0(raddr[2]),
    .raddr1(raddr[3]),
    .rdata0(entry[2]),
    .rdata1(entry[3])
  );

  lbci_blend #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_blend (
    .clk        (clk),
    .rst        (rst),
    .tag        (tag),
    .entry      (entry),
    .weight     (weight),
    .out_ready  (m_tready),
    .advance    (advance),
    .head_valid (head_valid),
    .out_valid  (m_tvalid),
    .out_channel(out_channel),
    .out_value  (out_value),
    .out_last   (m_tlast)
  );

  assign m_tdata = {3'b000, out_value, out_channel};

endmodule

// ===== src/lbci_checker.sv =====
// Port-level checks for the bilinear channel interpolator, bound to the top level.
module lbci_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // reset empties the pipeline and leaves the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

  // a query holds the input closed while its clamp and cell setup states run
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !s_tready ##1 !s_tready)
    else $error("input open during query setup");

  // a load leaves the block ready for the next transaction
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
    else $error("input closed after a load");

endmodule

bind lut_bilinear_channel_interpolator lbci_checker u_lbci_checker (.*);
